// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and signature tables of the payload threat scanner.
// No dependencies; used by pts_in_if, pts_hist_cell, the scanner and the testbench.
package pts_pkg;

	localparam int BYTE_W     = 8;
	localparam int POS_W      = 12;
	localparam int CNT_W      = 8;
	localparam int HIST_DEPTH = 11;
	localparam int NUM_PAT    = 3;

	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SLED_MIN_RUN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLED_SCAN_BYTES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT_HITS_LIMIT = 2'd2;

	localparam logic [CNT_W-1:0] SLED_MIN_RUN_RST      = 8'd4;
	localparam logic [POS_W-1:0] SLED_SCAN_BYTES_RST   = 12'd256;
	localparam logic [CNT_W-1:0] FORMAT_HITS_LIMIT_RST = 8'd3;

	localparam logic [POS_W-1:0]  POS_MAX     = 12'd4095;
	localparam logic [POS_W-1:0]  POS_SQL_MIN = 12'd4;
	localparam logic [CNT_W-1:0]  CNT_MAX     = 8'd255;
	localparam logic [BYTE_W-1:0] NOOP_BYTE   = 8'h90;
	localparam logic [BYTE_W-1:0] CH_PCT      = 8'h25;
	localparam logic [BYTE_W-1:0] CH_S        = 8'h73;
	localparam logic [BYTE_W-1:0] CH_N        = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_X        = 8'h78;
	localparam logic [BYTE_W-1:0] CH_P        = 8'h70;

	typedef enum logic [1:0] {
		THREAT_NONE   = 2'd0,
		THREAT_SHELL  = 2'd1,
		THREAT_SQL    = 2'd2,
		THREAT_FORMAT = 2'd3
	} threat_t;

	// history cell control
	typedef struct packed {
		logic shift;
		logic clear;
	} pts_ctl_t;

	// SQL signatures
	localparam int PAT_OR_ID    = 0;
	localparam int PAT_DROP_ID  = 1;
	localparam int PAT_UNION_ID = 2;

	localparam logic [7:0] PAT_OR [0:4] = '{8'h27, 8'h20, 8'h4F, 8'h52, 8'h20};
	localparam logic [7:0] PAT_DROP [0:6] =
		'{8'h27, 8'h3B, 8'h20, 8'h44, 8'h52, 8'h4F, 8'h50};
	localparam logic [7:0] PAT_UNION [0:11] =
		'{8'h55, 8'h4E, 8'h49, 8'h4F, 8'h4E, 8'h20,
		  8'h53, 8'h45, 8'h4C, 8'h45, 8'h43, 8'h54};

	function automatic int pat_len(input int p);
		int n;
		n = 0;
		case (p)
			PAT_OR_ID:    n = 5;
			PAT_DROP_ID:  n = 7;
			PAT_UNION_ID: n = 12;
			default:      n = 0;
		endcase
		return n;
	endfunction

	function automatic logic [BYTE_W-1:0] pat_char(input int p, input int i);
		logic [BYTE_W-1:0] c;
		c = '0;
		case (p)
			PAT_OR_ID:    c = PAT_OR[i[2:0]];
			PAT_DROP_ID:  c = PAT_DROP[i[2:0]];
			PAT_UNION_ID: c = PAT_UNION[i[3:0]];
			default:      c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/pts_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the payload threat scanner: one message byte per transaction.
// Depends on pts_pkg for field widths.
interface pts_in_if;
	logic                       valid;
	logic                       ready;
	logic [pts_pkg::BYTE_W-1:0] data_byte;
	logic                       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== rtl/pts_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the payload threat scanner: one threat code per message.
// No dependencies.
interface pts_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] threat_code;

	modport source (output valid, output threat_code, input ready);
	modport sink (input valid, input threat_code, output ready);
endinterface

// ===== rtl/pts_hist_cell.sv =====
`timescale 1ns / 1ps
// One byte of the history chain, with its fixed signature compares.
// Depends on pts_pkg.
module pts_hist_cell #(
	parameter int K = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pts_pkg::pts_ctl_t           ctl,
	input  logic [pts_pkg::BYTE_W-1:0]  din,
	output logic [pts_pkg::BYTE_W-1:0]  dout,
	output logic [pts_pkg::NUM_PAT-1:0] hit
);
	import pts_pkg::*;

	logic [BYTE_W-1:0] hist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctl.clear) begin
			hist_q <= '0;
		end else if (ctl.shift) begin
			hist_q <= din;
		end
	end

	assign dout = hist_q;

	// cell K holds the byte K+1 places back; it must match the signature
	// character that many places before the last one
	for (genvar p = 0; p < NUM_PAT; p++) begin : g_pat
		if (K + 1 < pat_len(p)) begin : g_cmp
			localparam logic [BYTE_W-1:0] NEED = pat_char(p, pat_len(p) - 2 - K);
			assign hit[p] = (hist_q == NEED);
		end else begin : g_free
			assign hit[p] = 1'b1;
		end
	end
endmodule

// ===== rtl/payload_threat_scanner.sv =====
`timescale 1ns / 1ps
// Payload threat scanner: classifies each message as shellcode, SQL injection,
// format string attack or clean. Depends on pts_pkg, pts_in_if, pts_out_if, pts_hist_cell.
//
// Usage:
//   in_ch  carries one message byte per transaction; end_of_message marks the
//          final byte. out_ch carries one threat code per message.
//   cfg_we/cfg_index/cfg_data write sled_min_run (0), sled_scan_bytes (1) and
//          format_hits_limit (2); other indexes are ignored. Write only while
//          no message is in flight.
// Throughput: one byte per cycle while in_ch.ready is high. All checks finish
//   in the cycle the byte is accepted; the history is an 11-cell shift chain,
//   each cell comparing its byte against fixed signature characters.
// Latency: the code is registered and shows on out_ch the cycle after the
//   final byte is accepted.
// Stall: in_ch.ready drops only while a code sits in the output register and
//   out_ch.ready is low; a code being taken frees room for a new byte in the
//   same cycle.
// Reset: registers return to their defaults, message state and history are
//   cleared, no code is pending. Message state is also cleared after each code.
module payload_threat_scanner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pts_pkg::CFG_W-1:0]     cfg_data,
	pts_in_if.sink                        in_ch,
	pts_out_if.source                     out_ch
);
	import pts_pkg::*;

	// configuration
	logic [CNT_W-1:0] sled_min_run_q;
	logic [POS_W-1:0] sled_scan_bytes_q;
	logic [CNT_W-1:0] format_hits_limit_q;

	// per-message state
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] noop_run_q;
	logic             shell_q;
	logic             sql_q;
	logic             zero_q;
	logic [CNT_W-1:0] fmt_q;

	// output register
	logic    out_valid_q;
	threat_t out_code_q;

	logic     accept;
	logic     last_byte;
	pts_ctl_t ctl;

	logic [BYTE_W-1:0]  hist [HIST_DEPTH];
	logic [NUM_PAT-1:0] cell_hit [HIST_DEPTH];
	logic [NUM_PAT-1:0] cur_hit;
	logic [NUM_PAT-1:0] pat_hit;

	logic             in_win;
	logic             is_noop;
	logic [CNT_W-1:0] run_inc;
	logic [CNT_W-1:0] noop_nxt;
	logic             shell_nxt;
	logic             zero_nxt;
	logic             sql_nxt;
	logic             fmt_pair;
	logic [CNT_W-1:0] fmt_nxt;
	logic [POS_W-1:0] pos_nxt;
	threat_t          code_nxt;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign last_byte   = in_ch.end_of_message;
	assign ctl.shift   = accept;
	assign ctl.clear   = accept && last_byte;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sled_min_run_q      <= SLED_MIN_RUN_RST;
			sled_scan_bytes_q   <= SLED_SCAN_BYTES_RST;
			format_hits_limit_q <= FORMAT_HITS_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLED_MIN_RUN:      sled_min_run_q      <= cfg_data[CNT_W-1:0];
				REG_SLED_SCAN_BYTES:   sled_scan_bytes_q   <= cfg_data[POS_W-1:0];
				REG_FORMAT_HITS_LIMIT: format_hits_limit_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// history chain: cell 0 holds the previous byte, cell 10 the oldest
	for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
		pts_hist_cell #(.K(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.din    ((k == 0) ? in_ch.data_byte : hist[(k == 0) ? 0 : k - 1]),
			.dout   (hist[k]),
			.hit    (cell_hit[k])
		);
	end

	// a signature ends here when the current byte is its last character and
	// every history cell agrees
	always_comb begin
		for (int p = 0; p < NUM_PAT; p++) begin
			cur_hit[p] = (in_ch.data_byte == pat_char(p, pat_len(p) - 1));
		end
		pat_hit = cur_hit;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			pat_hit = pat_hit & cell_hit[k];
		end
	end

	always_comb begin
		// no-op sled, only inside the scan window
		in_win    = (pos_q != POS_MAX) && (pos_q < sled_scan_bytes_q);
		is_noop   = (in_ch.data_byte == NOOP_BYTE);
		run_inc   = (noop_run_q == CNT_MAX) ? noop_run_q : noop_run_q + 1'b1;
		shell_nxt = shell_q || (in_win && is_noop && (run_inc >= sled_min_run_q));
		if (in_win) begin
			noop_nxt = is_noop ? run_inc : '0;
		end else begin
			noop_nxt = noop_run_q;
		end

		// SQL signatures stop at the first zero byte
		zero_nxt = zero_q || (in_ch.data_byte == '0);
		sql_nxt  = sql_q || ((in_ch.data_byte != '0) && !zero_q && (|pat_hit));

		// '%' followed by s, n, x or p
		fmt_pair = (pos_q != '0) && (hist[0] == CH_PCT) &&
			((in_ch.data_byte == CH_S) || (in_ch.data_byte == CH_N) ||
			 (in_ch.data_byte == CH_X) || (in_ch.data_byte == CH_P));
		fmt_nxt  = (fmt_pair && (fmt_q != CNT_MAX)) ? fmt_q + 1'b1 : fmt_q;

		pos_nxt = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;

		// priority: shellcode, SQL (message longer than 4 bytes), format
		if (shell_nxt) begin
			code_nxt = THREAT_SHELL;
		end else if (sql_nxt && (pos_q >= POS_SQL_MIN)) begin
			code_nxt = THREAT_SQL;
		end else if (fmt_nxt > format_hits_limit_q) begin
			code_nxt = THREAT_FORMAT;
		end else begin
			code_nxt = THREAT_NONE;
		end
	end

	// message state; cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			noop_run_q <= '0;
			shell_q    <= 1'b0;
			sql_q      <= 1'b0;
			zero_q     <= 1'b0;
			fmt_q      <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q      <= '0;
				noop_run_q <= '0;
				shell_q    <= 1'b0;
				sql_q      <= 1'b0;
				zero_q     <= 1'b0;
				fmt_q      <= '0;
			end else begin
				pos_q      <= pos_nxt;
				noop_run_q <= noop_nxt;
				shell_q    <= shell_nxt;
				sql_q      <= sql_nxt;
				zero_q     <= zero_nxt;
				fmt_q      <= fmt_nxt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			out_code_q <= code_nxt;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.threat_code = out_code_q;

	// a final byte always leaves a code pending
	a_code_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> out_valid_q)
		else $error("no code after final byte");

	// a fresh message starts from cleared state
	a_fresh_state: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == '0) |-> (fmt_q == '0 && noop_run_q == '0 && !shell_q && !sql_q && !zero_q))
		else $error("message state not cleared");

	// each format pair and each no-op byte consumes a byte position
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		({4'b0, fmt_q} <= pos_q) && ({4'b0, noop_run_q} <= pos_q))
		else $error("counter ahead of byte position");
endmodule

// ===== tb/payload_threat_scanner_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of payload_threat_scanner: drives message bytes, predicts
// the threat code of each message and checks every code on the output channel.
// Depends on pts_pkg, pts_in_if, pts_out_if and the scanner RTL.
module payload_threat_scanner_tb;
	import pts_pkg::*;

	localparam int          CLK_HALF_NS  = 2;
	localparam longint      TIMEOUT_NS   = 64'd10_000_000;
	localparam int          DRAIN_CYCLES = 6;
	localparam int          MAX_REPORTS  = 10;
	localparam int          HIST_LEN     = 11;

	// unused register index, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// byte values and limits of the scan rules
	localparam logic [7:0]  B_NOP    = 8'h90;
	localparam logic [7:0]  B_ZERO   = 8'h00;
	localparam logic [7:0]  B_PCT    = "%";
	localparam logic [7:0]  B_S      = "s";
	localparam logic [7:0]  B_N      = "n";
	localparam logic [7:0]  B_X      = "x";
	localparam logic [7:0]  B_P      = "p";
	localparam logic [11:0] POS_SAT  = 12'hFFF;
	localparam logic [7:0]  CNT_SAT  = 8'hFF;

	localparam logic [7:0]  MIN_RUN_DEFAULT = 8'd4;
	localparam logic [11:0] SCAN_DEFAULT    = 12'd256;
	localparam logic [7:0]  LIMIT_DEFAULT   = 8'd3;

	localparam string SIG_OR     = "' OR ";
	localparam string SIG_DROP   = "'; DROP";
	localparam string SIG_UNION  = "UNION SELECT";
	localparam string SPEC_CHARS = "snxp";
	localparam string ALPHABET   = "%snxp' ;ORDPUNISELCT";

	typedef enum int {
		IDLE_NONE,
		IDLE_SPARSE,
		IDLE_FULL
	} idle_mode_t;

	// one byte waiting for the driver, with the idle cycles that precede it
	typedef struct {
		logic [7:0]  data_byte;
		logic        end_of_message;
		int unsigned gap;
	} msg_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic       in_valid = 1'b0;
	logic [7:0] in_data = 8'h00;
	logic       in_eom = 1'b0;
	logic       out_ready = 1'b1;

	pts_in_if  in_ch ();
	pts_out_if out_ch ();

	assign in_ch.valid          = in_valid;
	assign in_ch.data_byte      = in_data;
	assign in_ch.end_of_message = in_eom;
	assign out_ch.ready         = out_ready;

	payload_threat_scanner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	initial begin
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	// stores shared by stimulus, driver and monitor
	msg_byte_t  pending_bytes [$];
	threat_t    expected_codes [$];
	logic [7:0] msg_body [$];
	int         error_count = 0;
	idle_mode_t sender_mode = IDLE_FULL;

	// --------------------------------------------------------------------
	// Scanner predictor: its own copy of registers and message state.
	// --------------------------------------------------------------------
	logic [7:0]  cfg_min_run;
	logic [11:0] cfg_scan;
	logic [7:0]  cfg_limit;

	logic [11:0] pos_q;
	logic [7:0]  run_q;
	bit          shell_q;
	bit          sql_q;
	bit          zero_q;
	logic [7:0]  fmt_q;
	logic [7:0]  hist_q [HIST_LEN];

	task automatic clear_scan();
		int k;
		pos_q   = '0;
		run_q   = '0;
		shell_q = 1'b0;
		sql_q   = 1'b0;
		zero_q  = 1'b0;
		fmt_q   = '0;
		for (k = 0; k < HIST_LEN; k++) hist_q[k] = 8'h00;
	endtask

	// does signature sig end with byte cur, the older bytes being in the history?
	function automatic bit sig_ends(input string sig, input logic [7:0] cur);
		int n;
		int k;
		n = sig.len();
		if (cur != sig[n-1]) return 1'b0;
		for (k = 0; k < n - 1; k++) begin
			if (hist_q[k] != sig[n-2-k]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the predicted scan by one accepted byte; queue a code at the last one
	task automatic scan_step(input logic [7:0] b, input logic last);
		logic [11:0] pos;
		threat_t     code;
		int          k;
		pos = pos_q;

		// no-op sled: only positions inside the window, saturated position never is
		if (pos < POS_SAT && pos < cfg_scan) begin
			if (b == B_NOP) begin
				if (run_q < CNT_SAT) run_q = run_q + 8'd1;
				if (run_q >= cfg_min_run) shell_q = 1'b1;
			end else begin
				run_q = '0;
			end
		end

		// SQL signatures stop matching from the first zero byte on
		if (b == B_ZERO) begin
			zero_q = 1'b1;
		end else if (!zero_q) begin
			if (sig_ends(SIG_OR, b) || sig_ends(SIG_DROP, b) || sig_ends(SIG_UNION, b))
				sql_q = 1'b1;
		end

		// format specifier pair: '%' then one of s n x p
		if (pos >= 12'd1 && hist_q[0] == B_PCT &&
				(b == B_S || b == B_N || b == B_X || b == B_P)) begin
			if (fmt_q < CNT_SAT) fmt_q = fmt_q + 8'd1;
		end

		for (k = HIST_LEN - 1; k > 0; k--) hist_q[k] = hist_q[k-1];
		hist_q[0] = b;
		if (pos_q < POS_SAT) pos_q = pos_q + 12'd1;

		if (last) begin
			if (shell_q)
				code = THREAT_SHELL;
			else if (sql_q && pos >= 12'd4)
				code = THREAT_SQL;
			else if (fmt_q > cfg_limit)
				code = THREAT_FORMAT;
			else
				code = THREAT_NONE;
			expected_codes.push_back(code);
			clear_scan();
		end
	endtask

	// idle cycles before one transaction, by idling mode
	function automatic int unsigned draw_wait(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:   return 0;
			IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
			default:     return $urandom_range(0, 18);
		endcase
	endfunction

	task automatic flag_error(input string what, input int exp_v, input int got_v);
		if (error_count < MAX_REPORTS)
			$display("[%0t] %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
		error_count++;
	endtask

	// --------------------------------------------------------------------
	// Driver: presents queued bytes, each after its own gap. valid gets at most one
	// nonblocking assignment per edge, so back-to-back bytes keep it high.
	// --------------------------------------------------------------------
	msg_byte_t   cur_byte;
	bit          holding = 1'b0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ch.ready) begin
				if (!holding && pending_bytes.size() != 0) begin
					cur_byte = pending_bytes.pop_front();
					holding  = 1'b1;
					gap_left = cur_byte.gap;
				end
				if (holding && gap_left == 0) begin
					in_valid <= 1'b1;
					in_data  <= cur_byte.data_byte;
					in_eom   <= cur_byte.end_of_message;
					holding  = 1'b0;
				end else begin
					if (holding) gap_left--;
					in_valid <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------------
	// Monitor: predicts on every accepted input transaction, checks every
	// accepted code transaction against the oldest expectation, and stalls
	// the output side. Receiver idling mode is redrawn every 8 codes.
	// --------------------------------------------------------------------
	int unsigned stall_left = 0;
	int          code_count = 0;
	idle_mode_t  rx_mode = IDLE_FULL;
	threat_t     want_code;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ch.ready) scan_step(in_data, in_eom);

			if (out_ch.valid && out_ready) begin
				if (expected_codes.size() == 0) begin
					flag_error("unexpected threat code", -1, int'(out_ch.threat_code));
				end else begin
					want_code = expected_codes.pop_front();
					if (out_ch.threat_code !== want_code)
						flag_error($sformatf("threat code of message %0d", code_count),
							int'(want_code), int'(out_ch.threat_code));
				end
				code_count++;
				if (code_count % 8 == 0) rx_mode = idle_mode_t'($urandom_range(0, 2));
				stall_left = draw_wait(rx_mode);
				out_ready <= (stall_left == 0);
			end else if (stall_left != 0) begin
				stall_left--;
				out_ready <= (stall_left == 0);
			end
		end
	end

	// --------------------------------------------------------------------
	// Stimulus helpers
	// --------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b, input bit last);
		msg_byte_t it;
		it.data_byte      = b;
		it.end_of_message = last;
		it.gap            = draw_wait(sender_mode);
		pending_bytes.push_back(it);
	endtask

	int bytes_queued = 0;

	// hand the message under construction to the driver, last byte flagged
	task automatic flush_message();
		int i;
		for (i = 0; i < msg_body.size(); i++)
			push_byte(msg_body[i], i == msg_body.size() - 1);
		bytes_queued += msg_body.size();
		msg_body.delete();
	endtask

	task automatic add_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++) msg_body.push_back(s[i]);
	endtask

	task automatic add_run(input logic [7:0] b, input int n);
		int i;
		for (i = 0; i < n; i++) msg_body.push_back(b);
	endtask

	// lowercase text: no '%', no uppercase, so no signature and no pair
	task automatic add_filler(input int n);
		int i;
		for (i = 0; i < n; i++) msg_body.push_back(8'($urandom_range(8'h61, 8'h7A)));
	endtask

	task automatic add_pairs(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			msg_body.push_back(B_PCT);
			msg_body.push_back(SPEC_CHARS[$urandom_range(0, 3)]);
		end
	endtask

	// mostly well-formed chunks (sled runs, signatures, specifier pairs), some
	// broken signatures, zero bytes and raw noise
	task automatic random_message(input int max_len);
		int    target;
		int    r;
		int    n;
		string sig;
		string alpha;
		target = $urandom_range(1, max_len);
		sender_mode = idle_mode_t'($urandom_range(0, 2));
		alpha = ALPHABET;
		while (msg_body.size() < target) begin
			r = $urandom_range(0, 19);
			if (r < 4) begin
				if ($urandom_range(0, 3) == 0)
					n = int'(cfg_min_run) + int'($urandom_range(0, 2)) - 1;
				else
					n = $urandom_range(1, 8);
				if (n < 1) n = 1;
				add_run(B_NOP, n);
			end else if (r < 8) begin
				case ($urandom_range(0, 2))
					0:       sig = SIG_OR;
					1:       sig = SIG_DROP;
					default: sig = SIG_UNION;
				endcase
				// broken signature: last character missing
				if ($urandom_range(0, 3) == 0) sig = sig.substr(0, sig.len() - 2);
				add_str(sig);
			end else if (r < 12) begin
				msg_body.push_back(B_PCT);
				if ($urandom_range(0, 3) == 0)
					msg_body.push_back(8'($urandom));
				else
					msg_body.push_back(SPEC_CHARS[$urandom_range(0, 3)]);
			end else if (r == 12) begin
				msg_body.push_back(B_ZERO);
			end else if (r < 17) begin
				msg_body.push_back(8'($urandom));
			end else begin
				msg_body.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
			end
		end
		flush_message();
	endtask

	task automatic random_traffic(input int n_bytes, input int max_len);
		int start;
		start = bytes_queued;
		while (bytes_queued - start < n_bytes) random_message(max_len);
	endtask

	// sender holds off until every code is back and the block had time to settle
	task automatic wait_drained();
		@(negedge clk);
		while (pending_bytes.size() != 0 || holding || in_valid ||
				expected_codes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_SLED_MIN_RUN:      cfg_min_run = data[7:0];
			REG_SLED_SCAN_BYTES:   cfg_scan    = data[11:0];
			REG_FORMAT_HITS_LIMIT: cfg_limit   = data[7:0];
			default: ;
		endcase
	endtask

	// new register setting; 8-bit registers get junk in the upper data bits,
	// and a write to the unused index must leave everything alone
	task automatic set_config(input logic [7:0] min_run, input logic [11:0] scan,
			input logic [7:0] limit);
		wait_drained();
		write_reg(REG_SLED_MIN_RUN, {4'($urandom), min_run});
		write_reg(REG_SLED_SCAN_BYTES, scan);
		write_reg(REG_FORMAT_HITS_LIMIT, {4'($urandom), limit});
		write_reg(REG_UNUSED, 12'($urandom));
		@(negedge clk);
	endtask

	function automatic logic [11:0] draw_scan();
		case ($urandom_range(0, 2))
			0:       return 12'd1;
			1:       return 12'($urandom_range(2, 40));
			default: return POS_SAT;
		endcase
	endfunction

	// --------------------------------------------------------------------
	// Test sequence
	// --------------------------------------------------------------------
	int ph;

	initial begin
		cfg_min_run = MIN_RUN_DEFAULT;
		cfg_scan    = SCAN_DEFAULT;
		cfg_limit   = LIMIT_DEFAULT;
		clear_scan();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, default registers: extreme bytes, each threat kind once
		sender_mode = idle_mode_t'($urandom_range(0, 2));
		msg_body.push_back(8'h00);
		flush_message();
		msg_body.push_back(8'hFF);
		flush_message();
		add_run(B_NOP, 4);
		flush_message();
		add_str(SIG_OR);
		flush_message();
		add_str("%s%n%x%p");
		flush_message();

		random_traffic(100, 24);
		wait_drained();
		random_traffic(50, 24);

		// shortest run, widest window, no pairs allowed
		set_config(8'd1, POS_SAT, 8'd0);
		random_traffic(70, 24);

		// largest run length: a run of exactly that many no-op bytes is flagged
		set_config(8'd255, POS_SAT, 8'd254);
		sender_mode = IDLE_SPARSE;
		add_run(B_NOP, 255);
		add_filler(1);
		flush_message();
		add_pairs(8);
		flush_message();

		// empty scan window with zero run length; pair limit that cannot be exceeded
		set_config(8'd0, 12'd0, 8'd255);
		sender_mode = IDLE_FULL;
		add_run(B_NOP, 10);
		flush_message();
		add_pairs(8);
		flush_message();
		random_traffic(30, 24);

		// zero run length: any no-op byte inside the window flags shellcode
		set_config(8'd0, 12'd64, 8'd255);
		random_traffic(50, 24);

		for (ph = 0; ph < 3; ph++) begin
			set_config(8'($urandom_range(1, 10)), draw_scan(), 8'($urandom_range(0, 6)));
			random_traffic(25, 32);
		end

		wait_drained();
		if (error_count == 0 && expected_codes.size() == 0) begin
			$display("payload_threat_scanner_tb: clean");
		end else begin
			if (expected_codes.size() != 0)
				$display("%0d threat codes never arrived", expected_codes.size());
			$display("payload_threat_scanner_tb: errors");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d bytes and %0d codes outstanding",
			pending_bytes.size(), expected_codes.size());
		$display("payload_threat_scanner_tb: errors");
		$finish;
	end

endmodule

// ===== payload_threat_scanner.f =====
rtl/pts_pkg.sv
rtl/pts_in_if.sv
rtl/pts_out_if.sv
rtl/pts_hist_cell.sv
rtl/payload_threat_scanner.sv
tb/payload_threat_scanner_tb.sv
